### rtl/core/vrst_pkg.sv
`timescale 1ns / 1ps

package vrst_pkg;

    // Coordinate format: signed Q12.12
    localparam int COORD_W    = 24;
    localparam int FRAC_BITS  = 12;

    // Sine and cosine format: signed Q1.14
    localparam int TRIG_FRAC  = 14;
    localparam int TRIG_W     = TRIG_FRAC + 2;
    localparam int TRIG_MAG_W = TRIG_FRAC + 1;

    // Quarter-wave table: Q1.16 magnitudes, rounded half up to TRIG_FRAC
    localparam int TABLE_FRAC = 16;
    localparam int TABLE_W    = TABLE_FRAC + 1;
    localparam int TRIG_SHIFT = TABLE_FRAC - TRIG_FRAC;

    // Angles in whole degrees
    localparam int ANGLE_W    = 9;
    localparam int QIDX_W     = 7;

    // Scale factors: signed Q4.12
    localparam int SCALE_W    = 16;
    localparam int SCALE_FRAC = 12;

    // Internal widths: rotated values grow past the coordinate range
    localparam int ROT_W      = COORD_W + 3;
    localparam int PROD_W     = ROT_W + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int SPROD_W    = ROT_W + SCALE_W;
    localparam int POS_W      = SPROD_W - SCALE_FRAC + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;

    localparam logic [ANGLE_W-1:0]  DEG_90  = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0]  DEG_180 = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0]  DEG_270 = ANGLE_W'(270);
    localparam logic [ANGLE_W:0]    DEG_360 = (ANGLE_W + 1)'(360);
    localparam logic [ANGLE_W:0]    DEG_90W = (ANGLE_W + 1)'(90);

    localparam logic [TABLE_W:0]        TABLE_HALF = (TABLE_W + 1)'(1) << (TRIG_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] TRIG_HALF  = SUM_W'(1) <<< (TRIG_FRAC - 1);
    localparam logic signed [SPROD_W:0] SCALE_HALF = (SPROD_W + 1)'(1) <<< (SCALE_FRAC - 1);
    localparam logic signed [TRIG_W-1:0]  TRIG_ONE  = TRIG_W'(1) <<< TRIG_FRAC;
    localparam logic signed [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) <<< SCALE_FRAC;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ROT_W-1:0]   t_rot;
    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } t_vertex;

    typedef struct packed {
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_result;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_X  = 3'd0,
        CFG_ANGLE_Y  = 3'd1,
        CFG_ANGLE_Z  = 3'd2,
        CFG_SCALE_X  = 3'd3,
        CFG_SCALE_Y  = 3'd4,
        CFG_OFFSET_X = 3'd5,
        CFG_OFFSET_Y = 3'd6
    } t_cfg_index;

    // Sine of 0..90 degrees, rounded half up from Q1.16 to TRIG_FRAC bits
    function automatic logic [TRIG_MAG_W-1:0] quarter_q(input logic [QIDX_W-1:0] d);
        logic [TABLE_W-1:0] raw;
        logic [TABLE_W:0]   sum;
        case (d)
            7'd0:  raw = 17'd0;     7'd1:  raw = 17'd1144;  7'd2:  raw = 17'd2287;
            7'd3:  raw = 17'd3430;  7'd4:  raw = 17'd4572;  7'd5:  raw = 17'd5712;
            7'd6:  raw = 17'd6850;  7'd7:  raw = 17'd7987;  7'd8:  raw = 17'd9121;
            7'd9:  raw = 17'd10252; 7'd10: raw = 17'd11380; 7'd11: raw = 17'd12505;
            7'd12: raw = 17'd13626; 7'd13: raw = 17'd14742; 7'd14: raw = 17'd15855;
            7'd15: raw = 17'd16962; 7'd16: raw = 17'd18064; 7'd17: raw = 17'd19161;
            7'd18: raw = 17'd20252; 7'd19: raw = 17'd21336; 7'd20: raw = 17'd22415;
            7'd21: raw = 17'd23486; 7'd22: raw = 17'd24550; 7'd23: raw = 17'd25607;
            7'd24: raw = 17'd26656; 7'd25: raw = 17'd27697; 7'd26: raw = 17'd28729;
            7'd27: raw = 17'd29753; 7'd28: raw = 17'd30767; 7'd29: raw = 17'd31772;
            7'd30: raw = 17'd32768; 7'd31: raw = 17'd33754; 7'd32: raw = 17'd34729;
            7'd33: raw = 17'd35693; 7'd34: raw = 17'd36647; 7'd35: raw = 17'd37590;
            7'd36: raw = 17'd38521; 7'd37: raw = 17'd39441; 7'd38: raw = 17'd40348;
            7'd39: raw = 17'd41243; 7'd40: raw = 17'd42126; 7'd41: raw = 17'd42995;
            7'd42: raw = 17'd43852; 7'd43: raw = 17'd44695; 7'd44: raw = 17'd45525;
            7'd45: raw = 17'd46341; 7'd46: raw = 17'd47143; 7'd47: raw = 17'd47930;
            7'd48: raw = 17'd48703; 7'd49: raw = 17'd49461; 7'd50: raw = 17'd50203;
            7'd51: raw = 17'd50931; 7'd52: raw = 17'd51643; 7'd53: raw = 17'd52339;
            7'd54: raw = 17'd53020; 7'd55: raw = 17'd53684; 7'd56: raw = 17'd54332;
            7'd57: raw = 17'd54963; 7'd58: raw = 17'd55578; 7'd59: raw = 17'd56175;
            7'd60: raw = 17'd56756; 7'd61: raw = 17'd57319; 7'd62: raw = 17'd57865;
            7'd63: raw = 17'd58393; 7'd64: raw = 17'd58903; 7'd65: raw = 17'd59396;
            7'd66: raw = 17'd59870; 7'd67: raw = 17'd60326; 7'd68: raw = 17'd60764;
            7'd69: raw = 17'd61183; 7'd70: raw = 17'd61584; 7'd71: raw = 17'd61966;
            7'd72: raw = 17'd62328; 7'd73: raw = 17'd62672; 7'd74: raw = 17'd62997;
            7'd75: raw = 17'd63303; 7'd76: raw = 17'd63589; 7'd77: raw = 17'd63856;
            7'd78: raw = 17'd64104; 7'd79: raw = 17'd64332; 7'd80: raw = 17'd64540;
            7'd81: raw = 17'd64729; 7'd82: raw = 17'd64898; 7'd83: raw = 17'd65048;
            7'd84: raw = 17'd65177; 7'd85: raw = 17'd65287; 7'd86: raw = 17'd65376;
            7'd87: raw = 17'd65446; 7'd88: raw = 17'd65496; 7'd89: raw = 17'd65526;
            default: raw = 17'd65536;
        endcase
        sum = {1'b0, raw} + TABLE_HALF;
        return sum[TRIG_SHIFT +: TRIG_MAG_W];
    endfunction

    // Fold a degree count below 720 into 0..359
    function automatic logic [ANGLE_W-1:0] wrap_deg(input logic [ANGLE_W:0] v);
        logic [ANGLE_W:0] diff;
        diff = v - DEG_360;
        return (v >= DEG_360) ? diff[ANGLE_W-1:0] : v[ANGLE_W-1:0];
    endfunction

    // Signed sine of 0..359 degrees by quadrant symmetry
    function automatic t_trig sine_q(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0]    d;
        logic                  neg;
        logic [TRIG_MAG_W-1:0] m;
        t_trig                 mag;
        if (a <= DEG_90) begin
            d   = a;
            neg = 1'b0;
        end else if (a <= DEG_180) begin
            d   = DEG_180 - a;
            neg = 1'b0;
        end else if (a <= DEG_270) begin
            d   = a - DEG_180;
            neg = 1'b1;
        end else begin
            d   = DEG_360[ANGLE_W-1:0] - a;
            neg = 1'b1;
        end
        m   = quarter_q(d[QIDX_W-1:0]);
        mag = $signed({1'b0, m});
        return neg ? -mag : mag;
    endfunction

    // Cosine as the sine a quarter turn ahead
    function automatic t_trig cos_q(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W:0] b;
        b = {1'b0, a} + DEG_90W;
        return sine_q(wrap_deg(b));
    endfunction

    // Clamp a wide signed value to the coordinate range
    function automatic t_coord sat_coord(input logic signed [POS_W-1:0] v);
        logic [POS_W-COORD_W:0] top;
        top = v[POS_W-1:COORD_W-1];
        if (top == '0 || top == '1) begin
            return v[COORD_W-1:0];
        end else if (v[POS_W-1]) begin
            return {1'b1, {(COORD_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W - 1){1'b1}}};
        end
    endfunction

endpackage

### rtl/core/vrst_rotate.sv
`timescale 1ns / 1ps

// Plane rotation of (a, b) by one angle over two stages:
// products first, then sum and round. The third coordinate rides along.
module vrst_rotate (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vrst_pkg::t_rot  i_a,
    input  vrst_pkg::t_rot  i_b,
    input  vrst_pkg::t_rot  i_p,
    input  vrst_pkg::t_trig i_cos,
    input  vrst_pkg::t_trig i_sin,
    output logic            o_valid,
    input  logic            i_ready,
    output vrst_pkg::t_rot  o_a,
    output vrst_pkg::t_rot  o_b,
    output vrst_pkg::t_rot  o_p
);
    import vrst_pkg::*;

    logic  r_m_valid;
    t_prod r_ac, r_bs, r_as, r_bc;
    t_rot  r_m_p;

    logic  r_s_valid;
    t_rot  r_s_a, r_s_b, r_s_p;

    logic  s_m_ready;
    logic  s_s_ready;
    logic signed [SUM_W-1:0] s_sum_a;
    logic signed [SUM_W-1:0] s_sum_b;

    // Each stage takes a beat when it is empty or its beat moves on
    assign s_s_ready = !r_s_valid || i_ready;
    assign s_m_ready = !r_m_valid || s_s_ready;
    assign o_ready   = s_m_ready;

    // Sum the products and round half up
    assign s_sum_a = SUM_W'(r_ac) - SUM_W'(r_bs) + TRIG_HALF;
    assign s_sum_b = SUM_W'(r_as) + SUM_W'(r_bc) + TRIG_HALF;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (s_m_ready) begin
                r_m_valid <= i_valid;
            end
            if (s_s_ready) begin
                r_s_valid <= r_m_valid;
            end
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (s_m_ready && i_valid) begin
            r_ac  <= PROD_W'(i_a * i_cos);
            r_bs  <= PROD_W'(i_b * i_sin);
            r_as  <= PROD_W'(i_a * i_sin);
            r_bc  <= PROD_W'(i_b * i_cos);
            r_m_p <= i_p;
        end
    end

    // Sum stage
    always_ff @(posedge i_clk) begin
        if (s_s_ready && r_m_valid) begin
            r_s_a <= s_sum_a[TRIG_FRAC +: ROT_W];
            r_s_b <= s_sum_b[TRIG_FRAC +: ROT_W];
            r_s_p <= r_m_p;
        end
    end

    assign o_valid = r_s_valid;
    assign o_a     = r_s_a;
    assign o_b     = r_s_b;
    assign o_p     = r_s_p;

endmodule

### rtl/core/vertex_rotate_scale_translate_unit.sv
`timescale 1ns / 1ps
// Vertex rotate / scale / translate unit.
//
// Input channel: one vertex (x, y, z, signed Q12.12) per beat on
// i_in_valid / o_in_ready. Output channel: one result per beat on
// o_out_valid / i_out_ready: rotated x and y as texture coordinates,
// and the scaled, offset position, all saturated to Q12.12.
// The vertex is rotated about Z, then Y, then X, then x and y are scaled
// and offset. Configuration beats on i_cfg_valid / o_cfg_ready write the
// register at i_cfg_index; the port is always ready. Angle writes are
// turned into sine and cosine right away, so a vertex may follow at once.
// The pipeline has two stages (multiply, sum) for each of the three
// rotations, one scale multiply stage and one offset/saturate stage.
// Throughput is one vertex per cycle while i_out_ready stays high.
// Each stage holds its beat while the next one is full, so a stalled
// receiver backs the stream up stage by stage without losing or
// repeating a beat; bubbles are squeezed out. Reset empties the
// pipeline and loads zero angles, unit scale and zero offsets.
module vertex_rotate_scale_translate_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  vrst_pkg::t_vertex                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output vrst_pkg::t_result                   o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vrst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vrst_pkg::COORD_W-1:0]        i_cfg_data
);
    import vrst_pkg::*;

    // Configuration
    t_trig                r_sin_x, r_cos_x, r_sin_y, r_cos_y, r_sin_z, r_cos_z;
    logic signed [SCALE_W-1:0] r_scale_x, r_scale_y;
    t_coord               r_off_x, r_off_y;
    logic [ANGLE_W-1:0]   s_cfg_angle;
    t_trig                s_cfg_sin, s_cfg_cos;

    // Rotation chain
    logic s_z_valid, s_z_ready, s_y_valid, s_y_ready, s_x_valid, s_x_ready;
    t_rot s_x1, s_y1, s_z0;
    t_rot s_z2, s_x2, s_y2;
    t_rot s_y3, s_z3, s_x3;

    // Scale stage
    logic r_c_valid;
    t_rot r_c_x, r_c_y, r_c_z;
    logic signed [SPROD_W-1:0] r_c_px, r_c_py;
    logic s_c_ready;

    // Offset and saturate stage
    logic    r_o_valid;
    t_result r_o_data;
    logic    s_f_ready;
    logic signed [SPROD_W:0] s_px_rnd, s_py_rnd;
    logic signed [POS_W-1:0] s_px, s_py;

    // Turn an angle write into sine and cosine
    assign s_cfg_angle = wrap_deg({1'b0, i_cfg_data[ANGLE_W-1:0]});
    assign s_cfg_sin   = sine_q(s_cfg_angle);
    assign s_cfg_cos   = cos_q(s_cfg_angle);
    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_x   <= '0;
            r_cos_x   <= TRIG_ONE;
            r_sin_y   <= '0;
            r_cos_y   <= TRIG_ONE;
            r_sin_z   <= '0;
            r_cos_z   <= TRIG_ONE;
            r_scale_x <= SCALE_ONE;
            r_scale_y <= SCALE_ONE;
            r_off_x   <= '0;
            r_off_y   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ANGLE_X: begin
                    r_sin_x <= s_cfg_sin;
                    r_cos_x <= s_cfg_cos;
                end
                CFG_ANGLE_Y: begin
                    r_sin_y <= s_cfg_sin;
                    r_cos_y <= s_cfg_cos;
                end
                CFG_ANGLE_Z: begin
                    r_sin_z <= s_cfg_sin;
                    r_cos_z <= s_cfg_cos;
                end
                CFG_SCALE_X:  r_scale_x <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:  r_scale_y <= i_cfg_data[SCALE_W-1:0];
                CFG_OFFSET_X: r_off_x   <= i_cfg_data;
                CFG_OFFSET_Y: r_off_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Rotate about Z: (x, y)
    vrst_rotate u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (s_z_ready),
        .i_a     (ROT_W'(i_in_data.vertex_x)),
        .i_b     (ROT_W'(i_in_data.vertex_y)),
        .i_p     (ROT_W'(i_in_data.vertex_z)),
        .i_cos   (r_cos_z),
        .i_sin   (r_sin_z),
        .o_valid (s_z_valid),
        .i_ready (s_y_ready),
        .o_a     (s_x1),
        .o_b     (s_y1),
        .o_p     (s_z0)
    );

    assign o_in_ready = s_z_ready;

    // Rotate about Y: (z, x)
    vrst_rotate u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_z_valid),
        .o_ready (s_y_ready),
        .i_a     (s_z0),
        .i_b     (s_x1),
        .i_p     (s_y1),
        .i_cos   (r_cos_y),
        .i_sin   (r_sin_y),
        .o_valid (s_y_valid),
        .i_ready (s_x_ready),
        .o_a     (s_z2),
        .o_b     (s_x2),
        .o_p     (s_y2)
    );

    // Rotate about X: (y, z)
    vrst_rotate u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_y_valid),
        .o_ready (s_x_ready),
        .i_a     (s_y2),
        .i_b     (s_z2),
        .i_p     (s_x2),
        .i_cos   (r_cos_x),
        .i_sin   (r_sin_x),
        .o_valid (s_x_valid),
        .i_ready (s_c_ready),
        .o_a     (s_y3),
        .o_b     (s_z3),
        .o_p     (s_x3)
    );

    // Stage handshakes
    assign s_f_ready = !r_o_valid || i_out_ready;
    assign s_c_ready = !r_c_valid || s_f_ready;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_c_ready) begin
                r_c_valid <= s_x_valid;
            end
            if (s_f_ready) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    // Scale multiply stage
    always_ff @(posedge i_clk) begin
        if (s_c_ready && s_x_valid) begin
            r_c_x  <= s_x3;
            r_c_y  <= s_y3;
            r_c_z  <= s_z3;
            r_c_px <= SPROD_W'(s_x3 * r_scale_x);
            r_c_py <= SPROD_W'(s_y3 * r_scale_y);
        end
    end

    // Round the scaled values and add offsets
    assign s_px_rnd = (SPROD_W + 1)'(r_c_px) + SCALE_HALF;
    assign s_py_rnd = (SPROD_W + 1)'(r_c_py) + SCALE_HALF;
    assign s_px     = s_px_rnd[SCALE_FRAC +: POS_W] + POS_W'(r_off_x);
    assign s_py     = s_py_rnd[SCALE_FRAC +: POS_W] + POS_W'(r_off_y);

    // Saturate into the output register
    always_ff @(posedge i_clk) begin
        if (s_f_ready && r_c_valid) begin
            r_o_data.tex_u <= sat_coord(POS_W'(r_c_x));
            r_o_data.tex_v <= sat_coord(POS_W'(r_c_y));
            r_o_data.pos_x <= sat_coord(s_px);
            r_o_data.pos_y <= sat_coord(s_py);
            r_o_data.pos_z <= sat_coord(POS_W'(r_c_z));
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // An empty output stage means every stage upstream can move
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output stage is empty");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A scaled beat that may move lands in the output stage
    a_scale_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && s_f_ready |=> o_out_valid)
        else $error("scale stage beat lost");

    // Sines stay within one
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sin_x <= TRIG_ONE && r_sin_x >= -TRIG_ONE &&
        r_sin_y <= TRIG_ONE && r_sin_y >= -TRIG_ONE &&
        r_sin_z <= TRIG_ONE && r_sin_z >= -TRIG_ONE)
        else $error("sine register out of range");

    // Cosines stay within one
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cos_x <= TRIG_ONE && r_cos_x >= -TRIG_ONE &&
        r_cos_y <= TRIG_ONE && r_cos_y >= -TRIG_ONE &&
        r_cos_z <= TRIG_ONE && r_cos_z >= -TRIG_ONE)
        else $error("cosine register out of range");

endmodule
